>>> sv/lkv_pkg.sv
// Shared constants, types and codes of the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

   // Store geometry
   localparam int CAPACITY = 4;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int STAMP_W = 32;

   // Stream payload widths
   localparam int REQ_TDATA_W = KEY_W + DATA_W;
   localparam int RSP_TDATA_W = DATA_W + KEY_W;
   localparam int RSP_TUSER_W = 2;

   // Request kinds
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Value returned by a get that misses
   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_free;
   } ctrl_sts_type;

endpackage

>>> sv/lkv_ctrl.sv
// Request sequencer of the LRU key-value cache.
`timescale 1ns / 1ps

module lkv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lkv_pkg::ctrl_sts_type sts,
   output lkv_pkg::ctrl_cmd_type cmd
);
   import lkv_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the result
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/lkv_datapath.sv
// Entry store, lookup, replacement choice and result register of the cache.
`timescale 1ns / 1ps

module lkv_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lkv_pkg::ctrl_cmd_type               cmd,
   output lkv_pkg::ctrl_sts_type               sts,
   input  logic                                req_tuser,
   input  logic [lkv_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lkv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [lkv_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);
   import lkv_pkg::*;

   // Captured request
   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_in_ff;

   // Entry store
   logic [KEY_W-1:0]   entry_keys_ff   [CAPACITY];
   logic [DATA_W-1:0]  entry_values_ff [CAPACITY];
   logic [STAMP_W-1:0] entry_stamps_ff [CAPACITY];
   logic [CNT_W-1:0]   fill_count_ff;
   logic [STAMP_W-1:0] use_counter_ff;
   logic [STAMP_W-1:0] use_counter_in;

   // Result register
   logic              rsp_valid_ff;
   logic              hit_ff;
   logic [DATA_W-1:0] data_out_ff;
   logic              evicted_ff;
   logic [KEY_W-1:0]  evicted_key_ff;

   // Lookup and replacement
   logic               hit_found;
   logic [SLOT_W-1:0]  hit_slot;
   logic [SLOT_W-1:0]  old_slot;
   logic [STAMP_W-1:0] old_stamp;
   logic               is_full;
   logic [SLOT_W-1:0]  free_slot;

   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   // Saturating use counter
   assign use_counter_in = (use_counter_ff == {STAMP_W{1'b1}}) ? use_counter_ff
                                                              : use_counter_ff + STAMP_W'(1);

   assign is_full   = (fill_count_ff == CNT_W'(CAPACITY));
   assign free_slot = fill_count_ff[SLOT_W-1:0];

   // Match the key against the valid entries, lowest slot wins
   always_comb begin
      hit_found = 1'b0;
      hit_slot  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < fill_count_ff) && (entry_keys_ff[i] == key_ff)) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_W'(i);
         end
      end
   end

   // Find the oldest stamp, lowest slot on a tie
   always_comb begin
      old_slot  = '0;
      old_stamp = entry_stamps_ff[0];
      for (int i = 1; i < CAPACITY; i++) begin
         if (entry_stamps_ff[i] < old_stamp) begin
            old_slot  = SLOT_W'(i);
            old_stamp = entry_stamps_ff[i];
         end
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         key_ff     <= req_tdata[KEY_W-1:0];
         data_in_ff <= req_tdata[KEY_W +: DATA_W];
      end
   end

   // Update entries and load the result
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff         <= hit_found;
         data_out_ff    <= '0;
         evicted_ff     <= 1'b0;
         evicted_key_ff <= '0;
         if (op_ff == OP_GET) begin
            if (hit_found) begin
               entry_stamps_ff[hit_slot] <= use_counter_in;
               data_out_ff               <= entry_values_ff[hit_slot];
            end else begin
               data_out_ff <= MISS_VALUE;
            end
         end else if (hit_found) begin
            entry_values_ff[hit_slot] <= data_in_ff;
            entry_stamps_ff[hit_slot] <= use_counter_in;
         end else if (!is_full) begin
            entry_keys_ff[free_slot]   <= key_ff;
            entry_values_ff[free_slot] <= data_in_ff;
            entry_stamps_ff[free_slot] <= use_counter_in;
         end else begin
            // replace the least recently used entry
            evicted_ff                <= 1'b1;
            evicted_key_ff            <= entry_keys_ff[old_slot];
            entry_keys_ff[old_slot]   <= key_ff;
            entry_values_ff[old_slot] <= data_in_ff;
            entry_stamps_ff[old_slot] <= use_counter_in;
         end
      end
   end

   // Control state: fill count, use counter, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff  <= '0;
         use_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.commit) begin
            use_counter_ff <= use_counter_in;
            if ((op_ff == OP_PUT) && !hit_found && !is_full) begin
               fill_count_ff <= fill_count_ff + CNT_W'(1);
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {evicted_key_ff, data_out_ff};
   assign rsp_tuser  = {evicted_ff, hit_ff};

endmodule

>>> sv/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on the req_ stream: req_tuser is the kind (0 get, 1 put),
//   req_tdata carries the key and the value to store. Every request gives
//   exactly one transfer on the rsp_ stream: hit and evicted flags in
//   rsp_tuser, the value read and the evicted key in rsp_tdata.
//   A request is first captured; then, in a second step, all entries are
//   matched in parallel, the oldest stamp is chosen and the store and the
//   result register are written. A new request is taken only once the
//   single lookup-and-writeback step of the last request has ended.
//   The result sits in an output register: a request is still taken while a
//   result waits, and the block holds its second step only when the result
//   register is still full and rsp_tready is low.
//   Reset empties the store (fill count zero) and clears the use counter;
//   entry contents need no clearing, as only filled slots are ever read.
module lru_key_value_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lkv_pkg::REQ_TDATA_W-1:0]     req_tdata,  // key, data_in
   input  logic                                req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lkv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // data_out, evicted_key
   output logic [lkv_pkg::RSP_TUSER_W-1:0]     rsp_tuser   // hit, evicted
);
   import lkv_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   lkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lkv_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
